@@ sv/srtf_pkg.sv @@
package srtf_pkg;

   localparam int MAX_PROCS = 16;
   localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CNT_W     = $clog2(MAX_PROCS + 1);

   localparam int LABEL_W = 16;
   localparam int TIME_W  = 12;
   localparam int TICK_W  = 17;
   localparam int TOT_W   = 21;
   localparam int PCNT_W  = 5;

   typedef struct packed {
      logic [LABEL_W-1:0] process_label;
      logic [TIME_W-1:0]  arrival_time;
      logic [TIME_W-1:0]  burst_time;
      logic               last;
   } req_type;

   typedef struct packed {
      logic [LABEL_W-1:0] result_label;
      logic [TIME_W-1:0]  result_arrival;
      logic [TIME_W-1:0]  result_burst;
      logic [TICK_W-1:0]  finish_time;
      logic [TICK_W-1:0]  turnaround_time;
      logic [TICK_W-1:0]  waiting_time;
      logic [TOT_W-1:0]   total_waiting;
      logic [TOT_W-1:0]   total_turnaround;
      logic [PCNT_W-1:0]  process_count;
      logic               last_row;
   } rsp_type;

endpackage

@@ sv/srtf_schedule_simulator.sv @@
// Shortest-remaining-time-first schedule simulator.
// Request channel (req_valid/req_ready/req_data): one process per request with
// label, arrival tick and burst length. A request is taken whenever the block
// is loading. Requests beyond MAX_PROCS are dropped; the request with
// last set starts the simulation, and req_ready stays low until all rows of the
// batch have been handed to the output register.
// Simulation: every tick is one pass over the n loaded processes plus one
// update step; a stretch with nothing ready is crossed in one pass by jumping
// to the next arrival. A scan over the n processes then sums turnaround and
// waiting times.
// Response channel (rsp_valid/rsp_ready/rsp_data): one row per process in load
// order, one row per cycle when the receiver takes them, each carrying the
// batch totals; last_row marks the final row. The row sits in an output
// register, so a stalled receiver only holds the current row, and loading of
// the next batch may begin while the final row still waits.
// Reset (synchronous, active high) empties the batch and drops any pending row.
module srtf_schedule_simulator import srtf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN,
      ST_APPLY,
      ST_SUM,
      ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   loaded_ff, loaded_in;
   logic [CNT_W-1:0]   unfinished_ff, unfinished_in;
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               found_ff, found_in;
   logic [TIME_W-1:0]  best_ff, best_in;
   logic [IDX_W-1:0]   pick_ff, pick_in;
   logic               have_next_ff, have_next_in;
   logic [TIME_W-1:0]  next_arr_ff, next_arr_in;
   logic [TOT_W-1:0]   tot_w_ff, tot_w_in;
   logic [TOT_W-1:0]   tot_t_ff, tot_t_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [LABEL_W-1:0] label_ff   [MAX_PROCS];
   logic [TIME_W-1:0]  arrival_ff [MAX_PROCS];
   logic [TIME_W-1:0]  burst_ff   [MAX_PROCS];
   logic [TIME_W-1:0]  remain_ff  [MAX_PROCS];
   logic [TICK_W-1:0]  finish_ff  [MAX_PROCS];

   logic               req_fire;
   logic               ld_we;
   logic               rem_we;
   logic               fin_we;
   logic               idx_last;
   logic [LABEL_W-1:0] cur_label;
   logic [TIME_W-1:0]  cur_arr;
   logic [TIME_W-1:0]  cur_burst;
   logic [TIME_W-1:0]  cur_rem;
   logic [TICK_W-1:0]  cur_fin;
   logic [TICK_W-1:0]  cur_tat;
   logic [TICK_W-1:0]  cur_wait;

   assign req_ready = (state_ff == ST_LOAD);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign cur_label = label_ff[idx_ff];
   assign cur_arr   = arrival_ff[idx_ff];
   assign cur_burst = burst_ff[idx_ff];
   assign cur_rem   = remain_ff[idx_ff];
   assign cur_fin   = finish_ff[idx_ff];
   assign cur_tat   = cur_fin - TICK_W'(cur_arr);
   assign cur_wait  = cur_tat - TICK_W'(cur_burst);
   assign idx_last  = ((CNT_W'(idx_ff) + CNT_W'(1)) == loaded_ff);

   always_comb begin
      state_in      = state_ff;
      loaded_in     = loaded_ff;
      unfinished_in = unfinished_ff;
      tick_in       = tick_ff;
      idx_in        = idx_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      pick_in       = pick_ff;
      have_next_in  = have_next_ff;
      next_arr_in   = next_arr_ff;
      tot_w_in      = tot_w_ff;
      tot_t_in      = tot_t_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      ld_we         = 1'b0;
      rem_we        = 1'b0;
      fin_we        = 1'b0;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               // drop the request when the batch is full
               if (loaded_ff < CNT_W'(MAX_PROCS)) begin
                  ld_we     = 1'b1;
                  loaded_in = loaded_ff + CNT_W'(1);
                  if (req_data.burst_time != '0) begin
                     unfinished_in = unfinished_ff + CNT_W'(1);
                  end
               end
               if (req_data.last) begin
                  state_in     = ST_SCAN;
                  idx_in       = '0;
                  found_in     = 1'b0;
                  have_next_in = 1'b0;
                  tick_in      = '0;
                  tot_w_in     = '0;
                  tot_t_in     = '0;
               end
            end
         end
         ST_SCAN: begin
            if (cur_rem != '0) begin
               if (TICK_W'(cur_arr) <= tick_ff) begin
                  if (!found_ff || (cur_rem < best_ff)) begin
                     found_in = 1'b1;
                     best_in  = cur_rem;
                     pick_in  = idx_ff;
                  end
               end else if (!have_next_ff || (cur_arr < next_arr_ff)) begin
                  have_next_in = 1'b1;
                  next_arr_in  = cur_arr;
               end
            end
            if (idx_last) begin
               state_in = ST_APPLY;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_APPLY: begin
            idx_in = '0;
            if (unfinished_ff == '0) begin
               state_in = ST_SUM;
            end else begin
               if (found_ff) begin
                  rem_we  = 1'b1;
                  tick_in = tick_ff + TICK_W'(1);
                  if (best_ff == TIME_W'(1)) begin
                     fin_we        = 1'b1;
                     unfinished_in = unfinished_ff - CNT_W'(1);
                  end
               end else begin
                  // nothing ready: skip ahead to the next arrival
                  tick_in = TICK_W'(next_arr_ff);
               end
               state_in     = ST_SCAN;
               found_in     = 1'b0;
               have_next_in = 1'b0;
            end
         end
         ST_SUM: begin
            tot_t_in = tot_t_ff + TOT_W'(cur_tat);
            tot_w_in = tot_w_ff + TOT_W'(cur_wait);
            if (idx_last) begin
               state_in = ST_EMIT;
               idx_in   = '0;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.result_label     = cur_label;
               rsp_data_in.result_arrival   = cur_arr;
               rsp_data_in.result_burst     = cur_burst;
               rsp_data_in.finish_time      = cur_fin;
               rsp_data_in.turnaround_time  = cur_tat;
               rsp_data_in.waiting_time     = cur_wait;
               rsp_data_in.total_waiting    = tot_w_ff;
               rsp_data_in.total_turnaround = tot_t_ff;
               rsp_data_in.process_count    = PCNT_W'(loaded_ff);
               rsp_data_in.last_row         = idx_last;
               if (idx_last) begin
                  state_in  = ST_LOAD;
                  loaded_in = '0;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         loaded_ff     <= '0;
         unfinished_ff <= '0;
         tick_ff       <= '0;
         idx_ff        <= '0;
         found_ff      <= 1'b0;
         have_next_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         loaded_ff     <= loaded_in;
         unfinished_ff <= unfinished_in;
         tick_ff       <= tick_in;
         idx_ff        <= idx_in;
         found_ff      <= found_in;
         have_next_ff  <= have_next_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      best_ff     <= best_in;
      pick_ff     <= pick_in;
      next_arr_ff <= next_arr_in;
      tot_w_ff    <= tot_w_in;
      tot_t_ff    <= tot_t_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (ld_we) begin
         label_ff[loaded_ff[IDX_W-1:0]]   <= req_data.process_label;
         arrival_ff[loaded_ff[IDX_W-1:0]] <= req_data.arrival_time;
         burst_ff[loaded_ff[IDX_W-1:0]]   <= req_data.burst_time;
         remain_ff[loaded_ff[IDX_W-1:0]]  <= req_data.burst_time;
         // a zero burst finishes at its arrival; others are overwritten later
         finish_ff[loaded_ff[IDX_W-1:0]]  <= TICK_W'(req_data.arrival_time);
      end
      if (rem_we) begin
         remain_ff[pick_ff] <= best_ff - TIME_W'(1);
      end
      if (fin_we) begin
         finish_ff[pick_ff] <= tick_ff + TICK_W'(1);
      end
   end

endmodule

@@ sv/srtf_checker.sv @@
module srtf_checker import srtf_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // hold a stalled row
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response row changed");

   // a final request starts the run, so no request is taken next cycle
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.last |=> !req_ready)
      else $error("request taken right after the final request");

   a_tat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.turnaround_time ==
         rsp_data.finish_time - TICK_W'(rsp_data.result_arrival))
      else $error("turnaround does not match finish and arrival");

   a_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.waiting_time ==
         rsp_data.turnaround_time - TICK_W'(rsp_data.result_burst))
      else $error("waiting time does not match turnaround and burst");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.process_count != '0)
      else $error("response row with empty batch");

endmodule

bind srtf_schedule_simulator srtf_checker u_srtf_checker (.*);
